/* rtl/brl_pkg.sv */
// Package for the line rasterizer: command codes and default sizes.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package brl_pkg;

    localparam int DEFAULT_COORD_BITS = 10;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

/* rtl/brl_front.sv */
// Front end: takes input beats, classifies the command and forms the
// endpoint deltas and step directions. Depends on brl_pkg.
`default_nettype none

module brl_front #(
    parameter int COORD_BITS = brl_pkg::DEFAULT_COORD_BITS,
    parameter int IN_W       = 40,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3
) (
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [IN_W-1:0]    i_s_tdata,
    input  wire logic               i_s_tuser,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output logic [ENTRY_W-1:0]      o_q_entry
);

    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_abs;
    logic [COORD_BITS:0]   dy_abs;
    logic                  is_start;

    assign x0 = i_s_tdata[COORD_BITS-1:0];
    assign y0 = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = i_s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign is_start = (i_s_tuser == brl_pkg::CMD_START);

    always_comb begin
        dx     = {1'b0, x1} - {1'b0, x0};
        dy     = {1'b0, y1} - {1'b0, y0};
        dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    end

    assign o_s_tready = ~i_q_full;
    assign o_q_push   = i_s_tvalid & ~i_q_full;
    assign o_q_entry  = {dy[COORD_BITS], dx[COORD_BITS],
                         dy_abs[COORD_BITS-1:0], dx_abs[COORD_BITS-1:0],
                         y0, x0, is_start};

endmodule

`default_nettype wire

/* rtl/brl_queue.sv */
// Short command queue between the front end and the stepper.
// Depends on brl_pkg for the status struct.
`default_nettype none

module brl_queue #(
    parameter int DEPTH   = brl_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ENTRY_W = 43
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [ENTRY_W-1:0] i_entry,
    input  wire logic               i_pop,
    output logic [ENTRY_W-1:0]      o_entry,
    output brl_pkg::t_queue_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/brl_back.sv */
// Back end: holds the line state, sets up or steps a line for each queued
// command and drives the output register. Depends on brl_pkg.
`default_nettype none

module brl_back #(
    parameter int COORD_BITS = brl_pkg::DEFAULT_COORD_BITS,
    parameter int OUT_W      = 24,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ENTRY_W-1:0] i_q_entry,
    input  wire logic               i_q_valid,
    output logic                    o_q_pop,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [OUT_W-1:0]        o_m_tdata,
    output logic                    o_m_tuser,
    output logic                    o_m_tlast
);

    localparam int CB  = COORD_BITS;
    localparam int E_W = COORD_BITS + 2;

    logic          e_start;
    logic [CB-1:0] e_x0;
    logic [CB-1:0] e_y0;
    logic [CB-1:0] e_adx;
    logic [CB-1:0] e_ady;
    logic          e_sx;
    logic          e_sy;

    logic [CB-1:0]  r_cur_x, n_cur_x;
    logic [CB-1:0]  r_cur_y, n_cur_y;
    logic [E_W-1:0] r_err, n_err;
    logic [E_W-1:0] r_diag, n_diag;
    logic [E_W-1:0] r_straight, n_straight;
    logic [CB-1:0]  r_steps, n_steps;
    logic           r_sx_neg, n_sx_neg;
    logic           r_sy_neg, n_sy_neg;
    logic           r_x_major, n_x_major;
    logic           r_active, n_active;

    logic           r_out_valid;
    logic [CB-1:0]  r_px, n_px;
    logic [CB-1:0]  r_py, n_py;
    logic           r_pvalid, n_pvalid;
    logic           r_plast, n_plast;

    logic           x_major;
    logic [E_W-1:0] dmaj;
    logic [E_W-1:0] dmin;
    logic [E_W-1:0] dmin_dmaj;
    logic           move_x;
    logic           move_y;

    assign {e_sy, e_sx, e_ady, e_adx, e_y0, e_x0, e_start} = i_q_entry;

    assign o_q_pop = i_q_valid & (~r_out_valid | i_m_tready);

    always_comb begin
        x_major   = (e_adx > e_ady);
        dmaj      = x_major ? {2'b00, e_adx} : {2'b00, e_ady};
        dmin      = x_major ? {2'b00, e_ady} : {2'b00, e_adx};
        dmin_dmaj = dmin - dmaj;

        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_err      = r_err;
        n_diag     = r_diag;
        n_straight = r_straight;
        n_steps    = r_steps;
        n_sx_neg   = r_sx_neg;
        n_sy_neg   = r_sy_neg;
        n_x_major  = r_x_major;
        n_active   = r_active;
        n_px       = '0;
        n_py       = '0;
        n_pvalid   = 1'b0;
        n_plast    = 1'b0;
        move_x     = 1'b0;
        move_y     = 1'b0;

        if (e_start) begin
            n_sx_neg   = e_sx;
            n_sy_neg   = e_sy;
            n_x_major  = x_major;
            n_err      = {dmin[E_W-2:0], 1'b0} - dmaj;
            n_diag     = {dmin_dmaj[E_W-2:0], 1'b0};
            n_straight = {dmin[E_W-2:0], 1'b0};
            n_steps    = dmaj[CB-1:0];
            n_cur_x    = e_x0;
            n_cur_y    = e_y0;
            n_active   = (dmaj[CB-1:0] != '0);
            n_px       = e_x0;
            n_py       = e_y0;
            n_pvalid   = 1'b1;
            n_plast    = (dmaj[CB-1:0] == '0);
        end else if (r_active) begin
            if (!r_err[E_W-1]) begin
                move_x = ~r_x_major;
                move_y = r_x_major;
                n_err  = r_err + r_diag;
            end else begin
                n_err  = r_err + r_straight;
            end
            if (r_x_major) begin
                move_x = 1'b1;
            end else begin
                move_y = 1'b1;
            end
            if (move_x) begin
                n_cur_x = r_sx_neg ? (r_cur_x - CB'(1)) : (r_cur_x + CB'(1));
            end
            if (move_y) begin
                n_cur_y = r_sy_neg ? (r_cur_y - CB'(1)) : (r_cur_y + CB'(1));
            end
            n_steps  = r_steps - CB'(1);
            n_active = (n_steps != '0);
            n_px     = n_cur_x;
            n_py     = n_cur_y;
            n_pvalid = 1'b1;
            n_plast  = (n_steps == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_err       <= '0;
            r_diag      <= '0;
            r_straight  <= '0;
            r_steps     <= '0;
            r_sx_neg    <= 1'b0;
            r_sy_neg    <= 1'b0;
            r_x_major   <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cur_x    <= n_cur_x;
                r_cur_y    <= n_cur_y;
                r_err      <= n_err;
                r_diag     <= n_diag;
                r_straight <= n_straight;
                r_steps    <= n_steps;
                r_sx_neg   <= n_sx_neg;
                r_sy_neg   <= n_sy_neg;
                r_x_major  <= n_x_major;
                r_active   <= n_active;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_px     <= n_px;
            r_py     <= n_py;
            r_pvalid <= n_pvalid;
            r_plast  <= n_plast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_py, r_px});
    assign o_m_tuser  = r_pvalid;
    assign o_m_tlast  = r_plast;

endmodule

`default_nettype wire

/* rtl/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: front end, command queue and
// stepper. Depends on brl_pkg, brl_front, brl_queue and brl_back.
//
// Usage: each input beat carries a command in tuser (start or advance) and
// the two endpoints in tdata. A start beat loads a new line and returns its
// first pixel; each advance beat returns the next pixel, with tlast set on
// the line's final endpoint. An advance with no line active returns a beat
// with tuser 0 and zero data. Every input beat gives exactly one output beat.
// An accepted input beat passes through the command queue and then the
// stepper's output register on its way to the output beat.
// Throughput is one beat per cycle while the receiver does not stall;
// the stepper updates the error term and steps the coordinate per beat.
// Reset empties the queue, drops any active line and clears the state.
// When the receiver stalls, the output register holds its beat, the queue
// takes up to QUEUE_DEPTH more input beats, and then tready goes low.
`default_nettype none

module bresenham_line_rasterizer #(
    parameter int COORD_BITS  = brl_pkg::DEFAULT_COORD_BITS,
    parameter int QUEUE_DEPTH = brl_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // x_start, y_start, x_end, y_end from the lowest bit up
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // cmd
    input  wire logic                                  i_s_tuser,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // pixel_x, pixel_y from the lowest bit up
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          o_m_tdata,
    // pixel_valid
    output logic                                       o_m_tuser,
    output logic                                       o_m_tlast
);

    localparam int IN_W    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int ENTRY_W = 4 * COORD_BITS + 3;

    logic                   q_push;
    logic                   q_pop;
    logic [ENTRY_W-1:0]     q_in_entry;
    logic [ENTRY_W-1:0]     q_out_entry;
    brl_pkg::t_queue_status q_status;

    brl_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_status.full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in_entry)
    );

    brl_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in_entry),
        .i_pop    (q_pop),
        .o_entry  (q_out_entry),
        .o_status (q_status)
    );

    brl_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_W      (OUT_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_entry  (q_out_entry),
        .i_q_valid  (~q_status.empty),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_no_pixel_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0 && !o_m_tlast))
        else $error("beat without a pixel carries data or tlast");

    a_queue_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("command queue is both full and empty");

    a_queued_cmd_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_status.empty && !o_m_tvalid) |=> o_m_tvalid)
        else $error("queued command was not issued to the output register");

    a_ready_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == !q_status.full)
        else $error("input ready disagrees with queue occupancy");

endmodule

`default_nettype wire

/* tb/bresenham_line_rasterizer_tb.sv */
// Self-checking testbench for bresenham_line_rasterizer: a random-gap stream driver,
// a stalling monitor and an in-bench Bresenham predictor that checks every pixel beat.
// Depends on brl_pkg and the rasterizer RTL under rtl.

module bresenham_line_rasterizer_tb;

    localparam int CB = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1450;

    typedef struct {
        logic          cmd;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
    } t_line_beat;

    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          valid;
        logic          last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    // x_start, y_start, x_end, y_end from the lowest bit up
    logic [39:0] i_s_tdata = '0;
    // cmd
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    // pixel_x, pixel_y from the lowest bit up
    logic [23:0] o_m_tdata;
    // pixel_valid
    logic o_m_tuser;
    logic o_m_tlast;

    bresenham_line_rasterizer #(
        .COORD_BITS(CB)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_line_beat pending_lines[$];
    t_pixel     expected_pixels[$];
    int         n_total = 0;
    int         n_accepted = 0;
    int         n_errors = 0;
    int         cycle_count = 0;
    int         src_gap = 0;
    int         sink_stall = 0;
    int         hold_cnt = 0;
    int         next_hold_at = 300;
    logic       calm = 1'b0;

    // Rasterizer state as the predictor sees it.
    logic [CB-1:0]        ras_x = '0;
    logic [CB-1:0]        ras_y = '0;
    logic signed [CB+1:0] ras_err = '0;
    logic signed [CB+1:0] ras_diag = '0;
    logic signed [CB+1:0] ras_straight = '0;
    logic [CB-1:0]        ras_steps = '0;
    logic                 ras_neg_x = 1'b0;
    logic                 ras_neg_y = 1'b0;
    logic                 ras_x_major = 1'b0;
    logic                 ras_active = 1'b0;

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void predict_pixel(input t_line_beat b);
        int     dx;
        int     dy;
        int     dmaj;
        int     dmin;
        t_pixel p;
        if (b.cmd == brl_pkg::CMD_START) begin
            dx = int'(b.xe) - int'(b.xs);
            dy = int'(b.ye) - int'(b.ys);
            ras_neg_x = dx < 0;
            ras_neg_y = dy < 0;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            ras_x_major = dx > dy;
            dmaj = ras_x_major ? dx : dy;
            dmin = ras_x_major ? dy : dx;
            ras_err = (CB+2)'(2 * dmin - dmaj);
            ras_diag = (CB+2)'(2 * (dmin - dmaj));
            ras_straight = (CB+2)'(2 * dmin);
            ras_steps = CB'(dmaj);
            ras_x = b.xs;
            ras_y = b.ys;
            ras_active = ras_steps != 0;
            p = '{ras_x, ras_y, 1'b1, ras_steps == 0};
        end else if (!ras_active) begin
            p = '{'0, '0, 1'b0, 1'b0};
        end else begin
            if (ras_err >= 0) begin
                if (ras_x_major) ras_y = ras_neg_y ? ras_y - 1'b1 : ras_y + 1'b1;
                else ras_x = ras_neg_x ? ras_x - 1'b1 : ras_x + 1'b1;
                ras_err = ras_err + ras_diag;
            end else begin
                ras_err = ras_err + ras_straight;
            end
            if (ras_x_major) ras_x = ras_neg_x ? ras_x - 1'b1 : ras_x + 1'b1;
            else ras_y = ras_neg_y ? ras_y - 1'b1 : ras_y + 1'b1;
            ras_steps = ras_steps - 1'b1;
            ras_active = ras_steps != 0;
            p = '{ras_x, ras_y, 1'b1, ras_steps == 0};
        end
        expected_pixels.push_back(p);
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        n_errors++;
        $display("mismatch %0s: expected %0d, got %0d (beat %0d out)", what, exp_v, got_v,
                 n_accepted - expected_pixels.size());
    endtask

    function automatic logic [CB-1:0] rand_coord();
        return CB'($urandom_range(0, (1 << CB) - 1));
    endfunction

    function automatic int near_coord(input int c, input int span);
        int v;
        v = c + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > (1 << CB) - 1) v = (1 << CB) - 1;
        return v;
    endfunction

    task automatic push_line(input int xs, input int ys, input int xe, input int ye,
                             input int n_adv);
        t_line_beat b;
        b = '{brl_pkg::CMD_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye)};
        pending_lines.push_back(b);
        repeat (n_adv) begin
            b = '{brl_pkg::CMD_ADVANCE, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord()};
            pending_lines.push_back(b);
        end
    endtask

    function automatic int line_len(input int xs, input int ys, input int xe, input int ye);
        int adx;
        int ady;
        adx = xe > xs ? xe - xs : xs - xe;
        ady = ye > ys ? ye - ys : ys - ye;
        return adx > ady ? adx : ady;
    endfunction

    // Stream driver: holds a beat until it is taken, then waits out a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_pixel(pending_lines.pop_front());
                n_accepted <= n_accepted + 1;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // Beat still waiting, keep it on the bus.
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_lines.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser <= pending_lines[0].cmd;
                i_s_tdata <= {pending_lines[0].ye, pending_lines[0].xe,
                              pending_lines[0].ys, pending_lines[0].xs};
                src_gap <= pick_idle();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output beat against the oldest predicted pixel.
    always @(posedge i_clk) begin
        t_pixel e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 1);
                end else begin
                    e = expected_pixels.pop_front();
                    if (o_m_tdata[CB-1:0] !== e.px)
                        report_mismatch("pixel_x", e.px, o_m_tdata[CB-1:0]);
                    if (o_m_tdata[2*CB-1:CB] !== e.py)
                        report_mismatch("pixel_y", e.py, o_m_tdata[2*CB-1:CB]);
                    if (o_m_tuser !== e.valid)
                        report_mismatch("pixel_valid", e.valid, o_m_tuser);
                    if (o_m_tlast !== e.last)
                        report_mismatch("last_pixel", e.last, o_m_tlast);
                end
            end
            if (sink_stall > 0) sink_stall <= sink_stall - 1;
            else sink_stall <= pick_idle();
            i_m_tready <= (sink_stall == 0) && (hold_cnt == 0);
        end
    end

    // Long receiver hold-offs, idle-free stretches and the run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (n_accepted >= next_hold_at) begin
            hold_cnt <= 120;
            next_hold_at <= next_hold_at + 500;
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int kind;
        int xs;
        int ys;
        int xe;
        int ye;
        int n;

        // Advance with no line, then a single-pixel line at the top corner.
        pending_lines.push_back('{brl_pkg::CMD_ADVANCE, '1, '1, '1, '1});
        push_line(1023, 1023, 1023, 1023, 1);
        push_line(10, 10, 13, 12, 4);
        push_line(7, 3, 5, 9, 6);
        push_line(2, 9, 5, 6, 3);
        push_line(0, 0, 1023, 0, 2);
        push_line(1023, 1023, 0, 1000, 1);
        push_line(0, 1023, 1023, 0, 2);

        while (pending_lines.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                xs = rand_coord();
                ys = rand_coord();
                xe = near_coord(xs, 20);
                ye = near_coord(ys, 20);
                n = line_len(xs, ys, xe, ye);
                if ($urandom_range(0, 9) < 3) n += $urandom_range(1, 2);
                push_line(xs, ys, xe, ye, n);
            end else if (kind < 75) begin
                // Lines against the edges of the coordinate range.
                xs = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(1015, 1023);
                ys = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(1015, 1023);
                xe = near_coord(xs, 12);
                ye = near_coord(ys, 12);
                push_line(xs, ys, xe, ye, line_len(xs, ys, xe, ye));
            end else if (kind < 85) begin
                // Diagonal and axis-aligned lines.
                xs = near_coord(512, 500);
                ys = near_coord(512, 500);
                n = $urandom_range(0, 15);
                case ($urandom_range(0, 2))
                    0: begin
                        xe = $urandom_range(0, 1) ? xs + n : xs - n;
                        ye = $urandom_range(0, 1) ? ys + n : ys - n;
                    end
                    1: begin
                        xe = xs;
                        ye = $urandom_range(0, 1) ? ys + n : ys - n;
                    end
                    default: begin
                        xe = $urandom_range(0, 1) ? xs + n : xs - n;
                        ye = ys;
                    end
                endcase
                push_line(xs, ys, xe, ye, n);
            end else if (kind < 93) begin
                // Long line abandoned part way by the next start.
                push_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 30));
            end else begin
                pending_lines.push_back('{brl_pkg::CMD_ADVANCE, rand_coord(), rand_coord(),
                                          rand_coord(), rand_coord()});
            end
        end
        n_total = pending_lines.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_pixels.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
